/* rtl/core/lcd_background_pixel_pipeline_assert.svh */
// ----------------------------------------------------------------------------
// LCD background pixel pipeline assertion macros
// Shared concurrent assertion forms used by the pipeline modules.
// ----------------------------------------------------------------------------
`ifndef LCD_BACKGROUND_PIXEL_PIPELINE_ASSERT_SVH
`define LCD_BACKGROUND_PIXEL_PIPELINE_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition a implies condition c at the same clock edge.
`define LBP_ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Condition a implies condition c at the next clock edge.
`define LBP_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define LBP_ASSERT_IMPLY(label, clk, rst, a, c)
`define LBP_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* rtl/core/lbp_pkg.sv */
// ----------------------------------------------------------------------------
// LCD background pixel pipeline package
// Types, constants and codes shared by the pipeline modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lbp_pkg;
   localparam int VramBytesDefault  = 8192;
   localparam int QueueDepthDefault = 16;

   localparam logic [12:0] MapHighBase   = 13'h1C00;
   localparam logic [12:0] MapLowBase    = 13'h1800;
   localparam logic [12:0] SetSignedBase = 13'h1000;
   localparam logic [8:0]  DotsPerLine   = 9'd456;
   localparam logic [7:0]  LastLine      = 8'd153;
   localparam logic [7:0]  LastVisible   = 8'd143;
   localparam logic [8:0]  DrawDotLimit  = 9'd289;
   localparam logic [8:0]  OamDots       = 9'd80;
   localparam logic [8:0]  ScreenWidth   = 9'd160;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_DRAW   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      FETCH_TILE = 2'd0,
      FETCH_LOW  = 2'd1,
      FETCH_HIGH = 2'd2,
      FETCH_PUSH = 2'd3
   } fetch_step_type;

   typedef enum logic [2:0] {
      CSR_LCD_CONTROL  = 3'd0,
      CSR_SCROLL_Y     = 3'd1,
      CSR_SCROLL_X     = 3'd2,
      CSR_COMPARE_LINE = 3'd3,
      CSR_IRQ_ENABLES  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CAP_TILE = 2'd0,
      CAP_LOW  = 2'd1,
      CAP_HIGH = 2'd2
   } capture_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } queue_ctrl_type;

   typedef struct packed {
      logic       can_push;
      logic       has_pixel;
      logic [1:0] head;
   } queue_status_type;
endpackage

/* rtl/core/lbp_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lbp_ram #(
   parameter int Width = 8,
   parameter int Depth = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

/* rtl/core/lbp_queue.sv */
// ----------------------------------------------------------------------------
// Background pixel queue
// Shift queue of two-bit pixels: eight pushed at the tail, one popped at head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lcd_background_pixel_pipeline_assert.svh"
module lbp_queue #(
   parameter int QueueDepth = lbp_pkg::QueueDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lbp_pkg::queue_ctrl_type   ctrl,
   input  logic [7:0]               plane_low,
   input  logic [7:0]               plane_high,
   output lbp_pkg::queue_status_type status
);
   import lbp_pkg::*;

   localparam int CountWidth = $clog2(QueueDepth + 1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic [1:0]            entry_ff [QueueDepth];
   logic [1:0]            entry_in [QueueDepth];
   logic [1:0]            pushed   [QueueDepth];

   assign status.can_push  = (count_ff <= CountWidth'(8));
   assign status.has_pixel = (count_ff > CountWidth'(8)) ||
                             (ctrl.push && (count_ff != '0));
   assign status.head      = entry_ff[0];

   always_comb begin
      int rel;
      for (int j = 0; j < QueueDepth; j++) begin
         rel = j - int'(count_ff);
         pushed[j] = entry_ff[j];
         if (ctrl.push && rel >= 0 && rel < 8) begin
            pushed[j] = {plane_high[7 - rel], plane_low[7 - rel]};
         end
      end
      for (int j = 0; j < QueueDepth; j++) begin
         if (ctrl.pop && j < QueueDepth - 1) begin
            entry_in[j] = pushed[j + 1];
         end else begin
            entry_in[j] = pushed[j];
         end
      end
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_in + CountWidth'(8);
      end
      if (ctrl.pop) begin
         count_in = count_in - CountWidth'(1);
      end
      if (ctrl.clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   `LBP_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CountWidth'(QueueDepth))
   `LBP_ASSERT_IMPLY(a_push_room, clock, reset, ctrl.push, count_ff <= CountWidth'(8))
   `LBP_ASSERT_NEXT(a_clear_empty, clock, reset, ctrl.clear, count_ff == '0)
endmodule

/* rtl/core/lcd_background_pixel_pipeline.sv */
// ----------------------------------------------------------------------------
// LCD background pixel pipeline
// Dot-clocked line/mode sequencer with a four-step background tile fetcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lcd_background_pixel_pipeline_assert.svh"
// Each input item is either one dot tick or one byte written into video RAM,
// and each accepted item yields exactly one result item in the next cycle, at
// one item per clock unless the output stalls. The only memory is video RAM, a
// synchronous RAM with one write and one read port; a VRAM write item uses
// the write port and a dot of the fetcher uses the read port, so the two
// never collide. The fetch data lands in the tile and plane registers at the
// end of the cycle after the read, just in time for the next fetch step, which
// comes two dots later at the earliest. Video RAM has no reset; reading a
// never-written byte gives undefined pixel colors. Results are held in an
// output register, and a new item is taken whenever that register is empty or
// being emptied.
module lcd_background_pixel_pipeline #(
   parameter int VramBytes  = lbp_pkg::VramBytesDefault,
   parameter int QueueDepth = lbp_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [12:0] req_vram_addr,
   input  logic [7:0]  req_vram_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pixel_valid,
   output logic [7:0]  rsp_pixel_x,
   output logic [7:0]  rsp_pixel_y,
   output logic [1:0]  rsp_color_index,
   output logic [1:0]  rsp_mode,
   output logic [7:0]  rsp_line,
   output logic        rsp_coincidence,
   output logic        rsp_vblank_irq,
   output logic        rsp_stat_irq,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   import lbp_pkg::*;

   localparam int AddrWidth = $clog2(VramBytes);

   // Configuration registers.
   logic [7:0] lcdc_ff, scy_ff, scx_ff, lyc_ff;
   logic [3:0] irq_en_ff;

   // Sequencer and fetcher state.
   mode_type       mode_ff, mode_in;
   fetch_step_type step_ff, step_in;
   logic           phase_ff, phase_in;
   logic [4:0]     column_ff, column_in;
   logic [7:0]     lpix_ff, lpix_in;
   logic [7:0]     line_ff, line_in;
   logic [8:0]     dots_ff, dots_in;
   logic           entered_ff, entered_in;
   logic           match_ff, match_in;
   logic [7:0]     tile_ff, plane_low_ff, plane_high_ff;

   // Pending VRAM read capture.
   logic        cap_valid_ff, cap_valid_in;
   capture_type cap_sel_ff, cap_sel_in;
   logic        cap_zero_ff, cap_zero_in;

   // Result register.
   logic       out_valid_ff;
   logic       pix_valid_ff, pix_valid_in;
   logic [7:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic [1:0] color_ff, color_in;
   logic       vb_ff, vb_in, st_ff, st_in;

   logic                 accept;
   logic                 dot;
   logic                 rd_en;
   logic [12:0]          rd_addr13;
   logic [7:0]           rd_data;
   logic [12:0]          map_addr, plane_addr;
   logic [7:0]           map_y;
   logic [4:0]           map_x;
   logic [12:0]          set_base;
   logic [2:0]           tile_row;
   logic [2:0]           fine_x;
   queue_ctrl_type       qctrl;
   queue_status_type     qstat;

   assign req_stall = out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign dot       = accept && !req_action;
   assign fine_x    = scx_ff[2:0];

   // Background map and tile-set address generation.
   assign map_y    = line_ff + scy_ff;
   assign map_x    = scx_ff[7:3] + column_ff;
   assign map_addr = (lcdc_ff[3] ? MapHighBase : MapLowBase) + {3'b000, map_y[7:3], map_x};
   assign tile_row = line_ff[2:0] + scy_ff[2:0];
   assign set_base = lcdc_ff[4] ? {1'b0, tile_ff, 4'b0000}
                                : SetSignedBase + {tile_ff[7], tile_ff, 4'b0000};

   lbp_ram #(
      .Width(8),
      .Depth(VramBytes)
   ) u_vram (
      .clock   (clock),
      .wr_en   (accept && req_action),
      .wr_addr (AddrWidth'(req_vram_addr)),
      .wr_data (req_vram_data),
      .rd_en   (rd_en),
      .rd_addr (AddrWidth'(rd_addr13)),
      .rd_data (rd_data)
   );

   lbp_queue #(
      .QueueDepth(QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (qctrl),
      .plane_low  (plane_low_ff),
      .plane_high (plane_high_ff),
      .status     (qstat)
   );

   // One dot of the line sequencer and background fetcher.
   always_comb begin
      mode_in      = mode_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      column_in    = column_ff;
      lpix_in      = lpix_ff;
      line_in      = line_ff;
      dots_in      = dots_ff;
      entered_in   = entered_ff;
      match_in     = match_ff;
      cap_valid_in = 1'b0;
      cap_sel_in   = CAP_TILE;
      cap_zero_in  = 1'b0;
      rd_en        = 1'b0;
      plane_addr   = set_base | {9'd0, tile_row, 1'b0};
      rd_addr13    = map_addr;
      qctrl        = '0;
      pix_valid_in = 1'b0;
      pix_x_in     = '0;
      pix_y_in     = '0;
      color_in     = '0;
      vb_in        = 1'b0;
      st_in        = 1'b0;
      if (dot) begin
         unique case (mode_ff)
            MODE_OAM: begin
               if (entered_ff) begin
                  entered_in = 1'b0;
                  match_in   = (line_ff == lyc_ff);
                  st_in      = ((line_ff == lyc_ff) && irq_en_ff[3]) || irq_en_ff[2];
               end
               dots_in = dots_ff + 9'd1;
               if (dots_in >= OamDots) begin
                  mode_in    = MODE_DRAW;
                  entered_in = 1'b1;
               end
            end
            MODE_DRAW: begin
               entered_in = 1'b0;
               dots_in    = dots_ff + 9'd1;
               phase_in   = !phase_ff;
               if (phase_ff) begin
                  unique case (step_ff)
                     FETCH_TILE: begin
                        if (lcdc_ff[0]) begin
                           rd_en        = 1'b1;
                           rd_addr13    = map_addr;
                           cap_valid_in = 1'b1;
                           cap_sel_in   = CAP_TILE;
                           column_in    = column_ff + 5'd1;
                        end
                        step_in = FETCH_LOW;
                     end
                     FETCH_LOW: begin
                        rd_en        = lcdc_ff[0];
                        rd_addr13    = plane_addr;
                        cap_valid_in = 1'b1;
                        cap_sel_in   = CAP_LOW;
                        cap_zero_in  = !lcdc_ff[0];
                        step_in      = FETCH_HIGH;
                     end
                     FETCH_HIGH: begin
                        rd_en        = lcdc_ff[0];
                        rd_addr13    = plane_addr | 13'd1;
                        cap_valid_in = 1'b1;
                        cap_sel_in   = CAP_HIGH;
                        cap_zero_in  = !lcdc_ff[0];
                        step_in      = FETCH_PUSH;
                     end
                     FETCH_PUSH: begin
                        if (qstat.can_push) begin
                           qctrl.push = 1'b1;
                           step_in    = FETCH_TILE;
                        end
                     end
                     default: step_in = FETCH_TILE;
                  endcase
               end
               if (qstat.has_pixel) begin
                  qctrl.pop = 1'b1;
                  if (lpix_ff >= {5'd0, fine_x} &&
                      ({1'b0, lpix_ff} - {6'd0, fine_x}) < ScreenWidth) begin
                     pix_valid_in = 1'b1;
                     pix_x_in     = lpix_ff - {5'd0, fine_x};
                     pix_y_in     = line_ff;
                     color_in     = qstat.head;
                  end
                  lpix_in = lpix_ff + 8'd1;
               end
               if ({1'b0, lpix_in} >= ({6'd0, fine_x} + ScreenWidth) ||
                   dots_in >= DrawDotLimit) begin
                  qctrl.clear = 1'b1;
                  step_in     = FETCH_TILE;
                  phase_in    = 1'b0;
                  column_in   = '0;
                  mode_in     = MODE_HBLANK;
                  entered_in  = 1'b1;
               end
            end
            MODE_HBLANK: begin
               if (entered_ff) begin
                  entered_in = 1'b0;
                  st_in      = irq_en_ff[0];
               end
               dots_in = dots_ff + 9'd1;
               if (dots_in >= DotsPerLine) begin
                  dots_in    = '0;
                  lpix_in    = '0;
                  line_in    = line_ff + 8'd1;
                  mode_in    = (line_ff >= LastVisible) ? MODE_VBLANK : MODE_OAM;
                  entered_in = 1'b1;
               end
            end
            MODE_VBLANK: begin
               if (entered_ff) begin
                  entered_in = 1'b0;
                  vb_in      = 1'b1;
                  st_in      = irq_en_ff[1];
               end
               if (dots_ff == '0) begin
                  match_in = (line_ff == lyc_ff);
                  if ((line_ff == lyc_ff) && irq_en_ff[3]) begin
                     st_in = 1'b1;
                  end
               end
               dots_in = dots_ff + 9'd1;
               if (dots_in >= DotsPerLine) begin
                  dots_in = '0;
                  lpix_in = '0;
                  line_in = line_ff + 8'd1;
                  if (line_in > LastLine) begin
                     line_in    = '0;
                     mode_in    = MODE_OAM;
                     entered_in = 1'b1;
                  end
               end
            end
            default: mode_in = MODE_OAM;
         endcase
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         lcdc_ff   <= 8'd145;
         scy_ff    <= '0;
         scx_ff    <= '0;
         lyc_ff    <= '0;
         irq_en_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LCD_CONTROL:  lcdc_ff   <= csr_write_data;
            CSR_SCROLL_Y:     scy_ff    <= csr_write_data;
            CSR_SCROLL_X:     scx_ff    <= csr_write_data;
            CSR_COMPARE_LINE: lyc_ff    <= csr_write_data;
            CSR_IRQ_ENABLES:  irq_en_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // Sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OAM;
         step_ff      <= FETCH_TILE;
         phase_ff     <= 1'b0;
         column_ff    <= '0;
         lpix_ff      <= '0;
         line_ff      <= '0;
         dots_ff      <= '0;
         entered_ff   <= 1'b1;
         match_ff     <= 1'b0;
         cap_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         column_ff    <= column_in;
         lpix_ff      <= lpix_in;
         line_ff      <= line_in;
         dots_ff      <= dots_in;
         entered_ff   <= entered_in;
         match_ff     <= match_in;
         cap_valid_ff <= cap_valid_in;
         if (accept) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Fetch data capture, in the cycle after the read is issued.
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_ff       <= '0;
         plane_low_ff  <= '0;
         plane_high_ff <= '0;
      end else if (cap_valid_ff) begin
         case (cap_sel_ff)
            CAP_TILE: tile_ff       <= rd_data;
            CAP_LOW:  plane_low_ff  <= cap_zero_ff ? 8'd0 : rd_data;
            CAP_HIGH: plane_high_ff <= cap_zero_ff ? 8'd0 : rd_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cap_sel_ff  <= cap_sel_in;
      cap_zero_ff <= cap_zero_in;
      if (accept) begin
         pix_valid_ff <= pix_valid_in;
         pix_x_ff     <= pix_x_in;
         pix_y_ff     <= pix_y_in;
         color_ff     <= color_in;
         vb_ff        <= vb_in;
         st_ff        <= st_in;
      end
   end

   // The mode, line and coincidence fields always show the state after the item.
   logic [1:0] rsp_mode_ff;
   logic [7:0] rsp_line_ff;
   logic       rsp_match_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff  <= mode_in;
         rsp_line_ff  <= line_in;
         rsp_match_ff <= match_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_valid = pix_valid_ff;
   assign rsp_pixel_x     = pix_x_ff;
   assign rsp_pixel_y     = pix_y_ff;
   assign rsp_color_index = color_ff;
   assign rsp_mode        = rsp_mode_ff;
   assign rsp_line        = rsp_line_ff;
   assign rsp_coincidence = rsp_match_ff;
   assign rsp_vblank_irq  = vb_ff;
   assign rsp_stat_irq    = st_ff;

   `LBP_ASSERT_IMPLY(a_line_range, clock, reset, 1'b1, line_ff <= LastLine)
   `LBP_ASSERT_IMPLY(a_vblank_lines, clock, reset, mode_ff == MODE_VBLANK, line_ff > LastVisible)
   `LBP_ASSERT_IMPLY(a_oam_dots, clock, reset, mode_ff == MODE_OAM, dots_ff < OamDots)
   `LBP_ASSERT_IMPLY(a_read_only_on_dot, clock, reset, rd_en, dot && mode_ff == MODE_DRAW)
endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// LCD background pixel pipeline testbench
// Fills the part of video RAM that fetches can reach, then runs dots and VRAM
// writes under a range of register settings, predicting every result item and
// comparing it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
   import lbp_pkg::*;

   // Upper bound on the run, far above the slowest correct run.
   localparam int CycleLimit = 3_000_000;

   typedef struct {
      logic       action;
      logic [12:0] addr;
      logic [7:0]  data;
   } dot_item_t;

   typedef struct {
      logic       pixel_valid;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [1:0] color_index;
      logic [1:0] mode;
      logic [7:0] line;
      logic       coincidence;
      logic       vblank_irq;
      logic       stat_irq;
   } pixel_result_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [12:0] req_vram_addr;
   logic [7:0]  req_vram_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_pixel_valid;
   logic [7:0]  rsp_pixel_x;
   logic [7:0]  rsp_pixel_y;
   logic [1:0]  rsp_color_index;
   logic [1:0]  rsp_mode;
   logic [7:0]  rsp_line;
   logic        rsp_coincidence;
   logic        rsp_vblank_irq;
   logic        rsp_stat_irq;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [7:0]  csr_write_data;

   lcd_background_pixel_pipeline i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_vram_addr(req_vram_addr), .req_vram_data(req_vram_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pixel_valid(rsp_pixel_valid), .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y), .rsp_color_index(rsp_color_index),
      .rsp_mode(rsp_mode), .rsp_line(rsp_line), .rsp_coincidence(rsp_coincidence),
      .rsp_vblank_irq(rsp_vblank_irq), .rsp_stat_irq(rsp_stat_irq),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Items waiting to be offered and results waiting to be seen.
   dot_item_t     pending_items[$];
   pixel_result_t expected_pixels[$];
   int            error_count = 0;
   bit            quiet = 0;
   int            send_gap = 0;
   int            recv_gap = 0;
   int unsigned   cycle_count = 0;

   // Shadow copy of the block's registers and state.
   logic [7:0]  ctl, scy, scx, lyc;
   logic [3:0]  irq_en;
   logic [7:0]  vram[8192];
   logic [1:0]  fifo[16];
   int unsigned fifo_count, fetch_step, fetch_phase, fetch_column;
   logic [7:0]  tile_id, plane_lo, plane_hi;
   int unsigned line_pixel, cur_line, line_dots;
   logic [1:0]  cur_mode;
   bit          mode_new, lyc_match;

   // The run covers only the first few lines, and vertical scroll is kept at
   // 0..4 or 255, so map reads stay in map rows 0 and 31. Map bytes hold only
   // the tile numbers below, so tile reads stay in their rows of both tile
   // sets. Only these bytes are ever written.
   logic [12:0] fill_addrs[$];
   logic [7:0]  tile_ids[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_fetcher();
      for (int i = 0; i < 16; i++) fifo[i] = 2'd0;
      fifo_count = 0;
      fetch_step = FETCH_TILE;
      fetch_phase = 0;
      fetch_column = 0;
   endfunction

   function automatic logic [7:0] read_plane(int unsigned hi);
      int a;
      if (!ctl[0]) return 8'd0;
      if (ctl[4]) a = int'(tile_id) * 16;
      else a = int'(SetSignedBase) + int'($signed(tile_id)) * 16;
      a = a + int'(hi) + 2 * int'((cur_line + scy) & 7);
      return vram[a & 13'h1FFF];
   endfunction

   function automatic void advance_fetcher();
      int unsigned mx, y, mapb;
      if (fetch_step == FETCH_TILE) begin
         if (ctl[0]) begin
            mapb = ctl[3] ? MapHighBase : MapLowBase;
            mx = ((scx >> 3) + fetch_column) & 32'h1F;
            y = (cur_line + scy) & 32'hFF;
            tile_id = vram[(mapb + mx + 32 * (y >> 3)) & 13'h1FFF];
            fetch_column = (fetch_column + 1) & 32'h1F;
         end
         fetch_step = FETCH_LOW;
      end else if (fetch_step == FETCH_LOW) begin
         plane_lo = read_plane(0);
         fetch_step = FETCH_HIGH;
      end else if (fetch_step == FETCH_HIGH) begin
         plane_hi = read_plane(1);
         fetch_step = FETCH_PUSH;
      end else if (fetch_count_ok()) begin
         for (int i = 0; i < 8; i++) begin
            fifo[fifo_count] = {plane_hi[7 - i], plane_lo[7 - i]};
            fifo_count++;
         end
         fetch_step = FETCH_TILE;
      end
   endfunction

   function automatic bit fetch_count_ok();
      return fifo_count <= 8;
   endfunction

   function automatic void enter_mode(logic [1:0] m);
      cur_mode = m;
      mode_new = 1;
   endfunction

   // Computes the one result that an accepted item causes.
   function automatic void step_pipeline(dot_item_t it);
      pixel_result_t r;
      int unsigned s;
      logic [1:0] c;
      r = '{default: '0};
      if (it.action) begin
         vram[it.addr] = it.data;
      end else if (cur_mode == MODE_OAM) begin
         if (mode_new) begin
            mode_new = 0;
            lyc_match = (cur_line == lyc);
            if (lyc_match && irq_en[3]) r.stat_irq = 1;
            if (irq_en[2]) r.stat_irq = 1;
         end
         line_dots++;
         if (line_dots >= OamDots) enter_mode(MODE_DRAW);
      end else if (cur_mode == MODE_DRAW) begin
         s = scx & 7;
         mode_new = 0;
         line_dots++;
         fetch_phase ^= 1;
         if (fetch_phase == 0) advance_fetcher();
         if (fifo_count > 8) begin
            c = fifo[0];
            for (int i = 0; i < 15; i++) fifo[i] = fifo[i + 1];
            fifo_count--;
            if (line_pixel >= s && line_pixel - s < ScreenWidth) begin
               r.pixel_valid = 1;
               r.pixel_x = 8'(line_pixel - s);
               r.pixel_y = 8'(cur_line);
               r.color_index = c;
            end
            line_pixel = (line_pixel + 1) & 32'hFF;
         end
         if (line_pixel >= s + ScreenWidth || line_dots >= DrawDotLimit) begin
            clear_fetcher();
            enter_mode(MODE_HBLANK);
         end
      end else if (cur_mode == MODE_HBLANK) begin
         if (mode_new) begin
            mode_new = 0;
            if (irq_en[0]) r.stat_irq = 1;
         end
         line_dots++;
         if (line_dots >= DotsPerLine) begin
            line_dots = 0;
            line_pixel = 0;
            enter_mode(cur_line >= LastVisible ? MODE_VBLANK : MODE_OAM);
            cur_line = (cur_line + 1) & 32'hFF;
         end
      end else begin
         if (mode_new) begin
            mode_new = 0;
            r.vblank_irq = 1;
            if (irq_en[1]) r.stat_irq = 1;
         end
         if (line_dots == 0) begin
            lyc_match = (cur_line == lyc);
            if (lyc_match && irq_en[3]) r.stat_irq = 1;
         end
         line_dots++;
         if (line_dots >= DotsPerLine) begin
            line_dots = 0;
            line_pixel = 0;
            cur_line = (cur_line + 1) & 32'hFF;
            if (cur_line > LastLine) begin
               cur_line = 0;
               enter_mode(MODE_OAM);
            end
         end
      end
      r.mode = cur_mode;
      r.line = 8'(cur_line);
      r.coincidence = lyc_match;
      expected_pixels.push_back(r);
   endfunction

   // The driver holds an item until it is taken and then loads the next one
   // from the pending queue, unless a random gap is running.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            step_pipeline('{req_action, req_vram_addr, req_vram_data});
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 19) == 0) begin
               send_gap <= $urandom_range(1, 16) - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_action <= pending_items[0].action;
               req_vram_addr <= pending_items[0].addr;
               req_vram_data <= pending_items[0].data;
               pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // The monitor takes result items, stalls in random bursts and compares
   // each item with the oldest prediction.
   always @(posedge clock) begin
      pixel_result_t e;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("result item with no prediction waiting");
               error_count++;
            end else begin
               e = expected_pixels.pop_front();
               check_field("pixel_valid", e.pixel_valid, rsp_pixel_valid);
               check_field("pixel_x", e.pixel_x, rsp_pixel_x);
               check_field("pixel_y", e.pixel_y, rsp_pixel_y);
               check_field("color_index", e.color_index, rsp_color_index);
               check_field("mode", e.mode, rsp_mode);
               check_field("line", e.line, rsp_line);
               check_field("coincidence", e.coincidence, rsp_coincidence);
               check_field("vblank_irq", e.vblank_irq, rsp_vblank_irq);
               check_field("stat_irq", e.stat_irq, rsp_stat_irq);
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
         end else if (!quiet && $urandom_range(0, 19) == 0) begin
            recv_gap <= $urandom_range(1, 16) - 1;
         end
         rsp_stall <= (recv_gap > 0) ||
                      (!quiet && recv_gap == 0 && $urandom_range(0, 19) == 0);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Waits until every item went in and every result came back, and then
   // lets the output register empty.
   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_LCD_CONTROL:  ctl = value;
         CSR_SCROLL_Y:     scy = value;
         CSR_SCROLL_X:     scx = value;
         CSR_COMPARE_LINE: lyc = value;
         default:          irq_en = value[3:0];
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Picks each register at one of its extremes or at random. Vertical
   // scroll stays where the written map rows cover every fetch.
   task automatic random_settings();
      write_reg(CSR_LCD_CONTROL, $urandom_range(0, 3) == 0 ?
                ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom));
      write_reg(CSR_SCROLL_Y, $urandom_range(0, 3) == 0 ?
                8'hFF : 8'($urandom_range(0, 4)));
      write_reg(CSR_SCROLL_X, $urandom_range(0, 3) == 0 ?
                ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom));
      write_reg(CSR_COMPARE_LINE, $urandom_range(0, 7) == 0 ?
                8'hFF : 8'($urandom_range(0, 153)));
      write_reg(CSR_IRQ_ENABLES, $urandom_range(0, 3) == 0 ?
                ($urandom_range(0, 1) ? 8'h0F : 8'h00) : 8'($urandom_range(0, 15)));
   endtask

   // Collects every byte address that a fetch can reach in this run.
   function automatic void build_fill_list();
      logic [12:0] set_rows[6] = '{13'h0000, 13'h07F0, 13'h0800,
                                   13'h0FF0, 13'h1000, 13'h17F0};
      for (int b = 0; b < 6; b++)
         for (int k = 0; k < 16; k++) fill_addrs.push_back(13'(set_rows[b] + k));
      for (int k = 0; k < 32; k++) begin
         fill_addrs.push_back(13'(MapLowBase + k));
         fill_addrs.push_back(13'(MapLowBase + 13'h3E0 + k));
         fill_addrs.push_back(13'(MapHighBase + k));
         fill_addrs.push_back(13'(MapHighBase + 13'h3E0 + k));
      end
   endfunction

   // A VRAM write whose byte keeps every later fetch on written bytes.
   function automatic dot_item_t make_write(logic [12:0] a);
      dot_item_t it;
      it.action = 1'b1;
      it.addr = a;
      if (a >= MapLowBase) it.data = tile_ids[$urandom_range(0, 3)];
      else it.data = 8'($urandom);
      return it;
   endfunction

   // Queues n items, of which about one in write_odds is a VRAM write.
   task automatic queue_items(int n, int write_odds);
      dot_item_t it;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1, write_odds) == 1) begin
            it = make_write(fill_addrs[$urandom_range(0, fill_addrs.size() - 1)]);
         end else begin
            it.action = 1'b0;
            it.addr = 13'($urandom);
            it.data = 8'($urandom);
         end
         pending_items.push_back(it);
      end
   endtask

   initial begin
      dot_item_t it;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = 1'b0;
      req_vram_addr = '0;
      req_vram_data = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      ctl = 8'd145;
      scy = 0;
      scx = 0;
      lyc = 0;
      irq_en = 0;
      clear_fetcher();
      tile_id = 0;
      plane_lo = 0;
      plane_hi = 0;
      line_pixel = 0;
      cur_line = 0;
      line_dots = 0;
      cur_mode = MODE_OAM;
      mode_new = 1;
      lyc_match = 0;
      build_fill_list();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Fill every reachable byte first, so that no fetch ever reads a byte
      // that was never written. The extreme addresses and bytes are included.
      foreach (fill_addrs[k]) begin
         it = make_write(fill_addrs[k]);
         if (it.addr == 13'h0000) it.data = 8'h00;
         if (it.addr == 13'h1FFF) it.data = 8'hFF;
         pending_items.push_back(it);
      end
      drain();

      // Directed start: control at reset value, the rest at zero, interrupts on;
      // then all ones, interrupts off. A short burst of items runs under each.
      write_reg(CSR_LCD_CONTROL, 8'd145);
      write_reg(CSR_SCROLL_Y, 8'h00);
      write_reg(CSR_SCROLL_X, 8'h00);
      write_reg(CSR_COMPARE_LINE, 8'h00);
      write_reg(CSR_IRQ_ENABLES, 8'h0F);
      queue_items(12, 1000);
      drain();
      write_reg(CSR_LCD_CONTROL, 8'hFF);
      write_reg(CSR_SCROLL_Y, 8'hFF);
      write_reg(CSR_SCROLL_X, 8'hFF);
      write_reg(CSR_COMPARE_LINE, 8'hFF);
      write_reg(CSR_IRQ_ENABLES, 8'h00);
      queue_items(12, 4);
      drain();

      // Random phases. Settings change between phases, and so also in the
      // middle of a line, which exercises the scroll-change cases.
      for (int p = 0; p < 10; p++) begin
         random_settings();
         queue_items(60, 10);
         drain();
      end

      // A longer stretch across the end of a line, and a last one that runs
      // without any idling.
      random_settings();
      queue_items(150, 10);
      drain();
      quiet = 1;
      random_settings();
      queue_items(100, 10);
      drain();
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
